[sv/skl_pkg.sv]
`default_nettype none

package skl_pkg;

  localparam int MAX_TAPS       = 16;
  localparam int CHANNEL_BITS   = 16;
  localparam int NUM_CHAN       = 4;
  localparam int COEF_W         = 16;
  localparam int COEFS_PER_WORD = 4;
  localparam int NUM_COEF_WORDS = 4;
  localparam int NUM_COEF       = COEFS_PER_WORD * NUM_COEF_WORDS;
  localparam int CFG_DATA_W     = COEF_W * COEFS_PER_WORD;
  localparam int CFG_IDX_W      = 3;
  localparam int TAPCNT_W       = 5;
  localparam int FRAC_BITS      = 16;

  localparam int WIN_DEPTH = 2 * MAX_TAPS - 1;
  localparam int ADDR_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int TAP_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int RCV_W     = $clog2(WIN_DEPTH + 1);
  localparam int PAIR_W    = CHANNEL_BITS + 1;
  localparam int PROD_W    = COEF_W + PAIR_W;
  localparam int ACC_W     = PROD_W + TAP_W;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0]    pix_t;
  typedef logic [COEF_W-1:0]       coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_COUNT = 3'd0,
    CFG_COEF_A    = 3'd1,
    CFG_COEF_B    = 3'd2,
    CFG_COEF_C    = 3'd3,
    CFG_COEF_D    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic  issue;
    logic  center;
    logic  clear;
    coef_t coef;
  } mac_ctl_t;

  // tap count clamped to 1 .. MAX_TAPS, minus one
  function automatic logic [TAP_W-1:0] taps_m1_of(input logic [TAPCNT_W-1:0] tc);
    int t;
    t = int'(tc);
    if (t < 1) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    return TAP_W'(t - 1);
  endfunction

  // address of the pixel i places behind the newest one
  function automatic logic [ADDR_W-1:0] win_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] i);
    logic [ADDR_W:0] diff;
    diff = {1'b0, base} - {1'b0, i};
    if (diff[ADDR_W]) diff = diff + (ADDR_W+1)'(WIN_DEPTH);
    return diff[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/skl_if.sv]
`default_nettype none

interface skl_in_if;
  import skl_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;
  chan_t alpha_in;
  logic  line_end_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, line_end_in,
                  input ready);
  modport sink (input valid, red_in, green_in, blue_in, alpha_in, line_end_in,
                output ready);
endinterface

interface skl_out_if;
  import skl_pkg::*;
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  chan_t alpha_out;
  logic  line_end_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, line_end_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, line_end_out,
                output ready);
endinterface

interface skl_cfg_if;
  import skl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/skl_window_ram.sv]
`default_nettype none

module skl_window_ram (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire  [skl_pkg::ADDR_W-1:0] waddr_i,
  input  skl_pkg::pix_t             wdata_i,
  input  wire  [skl_pkg::ADDR_W-1:0] raddr_a_i,
  input  wire  [skl_pkg::ADDR_W-1:0] raddr_b_i,
  output skl_pkg::pix_t             rdata_a_o,
  output skl_pkg::pix_t             rdata_b_o
);
  import skl_pkg::*;

  pix_t mem [WIN_DEPTH];
  pix_t rdata_a_q;
  pix_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[sv/skl_mac.sv]
`default_nettype none

module skl_mac (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  skl_pkg::mac_ctl_t  ctl_i,
  input  skl_pkg::pix_t      rdata_a_i,
  input  skl_pkg::pix_t      rdata_b_i,
  output logic               busy_o,
  output skl_pkg::pix_t      result_o
);
  import skl_pkg::*;

  logic                s1_valid_q, s2_valid_q, s3_valid_q;
  logic                s1_center_q;
  coef_t               s1_coef_q, s2_coef_q;
  logic [PAIR_W-1:0]   s2_pair_q [NUM_CHAN];
  logic [PROD_W-1:0]   s3_prod_q [NUM_CHAN];
  logic [ACC_W-1:0]    acc_q     [NUM_CHAN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= ctl_i.issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // read data lines up with the registered control
  always_ff @(posedge clk_i) begin
    s1_center_q <= ctl_i.center;
    s1_coef_q   <= ctl_i.coef;
    s2_coef_q   <= s1_coef_q;
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (s1_center_q) begin
        s2_pair_q[c] <= {1'b0, rdata_a_i[c]};
      end else begin
        s2_pair_q[c] <= {1'b0, rdata_a_i[c]} + {1'b0, rdata_b_i[c]};
      end
      s3_prod_q[c] <= PROD_W'(s2_coef_q) * PROD_W'(s2_pair_q[c]);
      if (ctl_i.clear) begin
        acc_q[c] <= '0;
      end else if (s3_valid_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(s3_prod_q[c]);
      end
    end
  end

  assign busy_o = s1_valid_q | s2_valid_q | s3_valid_q;

  // round half up, then saturate
  always_comb begin
    logic [ACC_W:0] rnd;
    for (int c = 0; c < NUM_CHAN; c++) begin
      rnd = {1'b0, acc_q[c]} + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
      if (|rnd[ACC_W:FRAC_BITS+CHANNEL_BITS]) begin
        result_o[c] = '1;
      end else begin
        result_o[c] = rnd[FRAC_BITS +: CHANNEL_BITS];
      end
    end
  end

endmodule

`default_nettype wire

[sv/symmetric_kernel_line_blur.sv]
// an item that gives a result goes from its accept through T tap issues and the drain
// of the single multiply-accumulate unit, one tap pair per cycle, to a finish step that
// loads the result register once no stalled result is held, T = taps in use; a line end
// repeats issue, drain and finish per result; new pixels are taken only while idle
// reset: asynchronous, active low; counters and handshakes clear, T = 1, c0 = 65535
// the pixel window ram has no reset and needs no clearing pass
`default_nettype none

module symmetric_kernel_line_blur (
  input wire         clk_i,
  input wire         rst_ni,
  skl_in_if.sink     pix_i,
  skl_out_if.source  pix_o,
  skl_cfg_if.sink    cfg_i
);
  import skl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [TAPCNT_W-1:0] tap_q;
  coef_t               coef_q [NUM_COEF];

  logic [TAP_W-1:0]    k_q, k_d;
  logic [TAP_W-1:0]    d_q, d_d;
  logic [TAP_W-1:0]    tm1_q, tm1_d;
  logic [ADDR_W-1:0]   n_q, n_d;
  logic [ADDR_W-1:0]   newest_q, newest_d;
  logic [RCV_W-1:0]    rcv_q, rcv_d;
  logic                lend_q, lend_d;

  logic                out_valid_q, out_valid_d;
  logic                out_lend_q;
  pix_t                out_pix_q;
  logic                out_load;

  logic                in_acc;
  logic [ADDR_W-1:0]   n_now;
  logic [TAP_W-1:0]    tm1_now;
  logic [ADDR_W-1:0]   waddr;
  pix_t                wpix;
  logic [ADDR_W-1:0]   dk_sum, ri, li, raddr_a, raddr_b;
  coef_t               coef_sel;
  mac_ctl_t            mac_ctl;
  logic                mac_busy;
  pix_t                mac_res;
  pix_t                rdata_a, rdata_b;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= TAPCNT_W'(1);
      for (int j = 0; j < NUM_COEF; j++) begin
        coef_q[j] <= (j == 0) ? '1 : '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index) inside
        CFG_TAP_COUNT: begin
          tap_q <= cfg_i.data[TAPCNT_W-1:0];
        end
        CFG_COEF_A, CFG_COEF_B, CFG_COEF_C, CFG_COEF_D: begin
          for (int w = 0; w < NUM_COEF_WORDS; w++) begin
            if (int'(cfg_i.index) == int'(CFG_COEF_A) + w) begin
              for (int j = 0; j < COEFS_PER_WORD; j++) begin
                coef_q[w*COEFS_PER_WORD+j] <= cfg_i.data[j*COEF_W +: COEF_W];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // request side
  assign pix_i.ready = (state_q == ST_IDLE);
  assign in_acc      = pix_i.valid && pix_i.ready;

  assign n_now   = (rcv_q < RCV_W'(WIN_DEPTH - 1)) ? rcv_q[ADDR_W-1:0]
                                                   : ADDR_W'(WIN_DEPTH - 1);
  assign tm1_now = taps_m1_of(tap_q);
  assign waddr   = (newest_q == ADDR_W'(WIN_DEPTH - 1)) ? '0 : newest_q + ADDR_W'(1);

  always_comb begin
    wpix[0] = pix_i.red_in;
    wpix[1] = pix_i.green_in;
    wpix[2] = pix_i.blue_in;
    wpix[3] = pix_i.alpha_in;
  end

  // neighbour addresses, clamped at both line ends
  assign dk_sum  = ADDR_W'(d_q) + ADDR_W'(k_q);
  assign ri      = (k_q >= d_q) ? '0 : ADDR_W'(d_q - k_q);
  assign li      = (dk_sum < n_q) ? dk_sum : n_q;
  assign raddr_a = win_addr(newest_q, (k_q == '0) ? ADDR_W'(d_q) : ri);
  assign raddr_b = win_addr(newest_q, li);

  always_comb begin
    coef_sel = '0;
    for (int j = 0; j < NUM_COEF; j++) begin
      if (int'(k_q) == j) coef_sel = coef_q[j];
    end
  end

  always_comb begin
    mac_ctl.issue  = (state_q == ST_ISSUE);
    mac_ctl.center = (k_q == '0);
    mac_ctl.clear  = (state_q == ST_ISSUE) && (k_q == '0);
    mac_ctl.coef   = coef_sel;
  end

  skl_window_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .waddr_i   (waddr),
    .wdata_i   (wpix),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  skl_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .busy_o    (mac_busy),
    .result_o  (mac_res)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    d_d         = d_q;
    tm1_d       = tm1_q;
    n_d         = n_q;
    newest_d    = newest_q;
    rcv_d       = rcv_q;
    lend_d      = lend_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !pix_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          newest_d = waddr;
          n_d      = n_now;
          tm1_d    = tm1_now;
          lend_d   = pix_i.line_end_in;
          k_d      = '0;
          if (pix_i.line_end_in) begin
            rcv_d   = '0;
            d_d     = (n_now < ADDR_W'(tm1_now)) ? n_now[TAP_W-1:0] : tm1_now;
            state_d = ST_ISSUE;
          end else begin
            if (rcv_q < RCV_W'(WIN_DEPTH)) rcv_d = rcv_q + RCV_W'(1);
            d_d = tm1_now;
            if (n_now >= ADDR_W'(tm1_now)) state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (k_q == tm1_q) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + TAP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || pix_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (lend_q && (d_q != '0)) begin
            d_d     = d_q - TAP_W'(1);
            k_d     = '0;
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      d_q         <= '0;
      tm1_q       <= '0;
      n_q         <= '0;
      newest_q    <= '0;
      rcv_q       <= '0;
      lend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      d_q         <= d_d;
      tm1_q       <= tm1_d;
      n_q         <= n_d;
      newest_q    <= newest_d;
      rcv_q       <= rcv_d;
      lend_q      <= lend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= mac_res;
      out_lend_q <= lend_q && (d_q == '0);
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.red_out      = out_pix_q[0];
  assign pix_o.green_out    = out_pix_q[1];
  assign pix_o.blue_out     = out_pix_q[2];
  assign pix_o.alpha_out    = out_pix_q[3];
  assign pix_o.line_end_out = out_lend_q;

endmodule

`default_nettype wire

[sv/skl_checker.sv]
`default_nettype none

module skl_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_i,
  input wire                         in_line_end_i,
  input wire                         out_valid_i,
  input wire                         out_ready_i,
  input wire [skl_pkg::CHANNEL_BITS-1:0] out_red_i,
  input wire                         out_line_end_i
);
  import skl_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_red_i) && $stable(out_line_end_i)))
    else $error("stalled result changed");

  // a line end always starts work, so requests stop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_line_end_i) |=> !in_ready_i)
    else $error("ready after line end");

  // no result right after a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result too early");

  // results are loaded only while requests are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result loaded while ready");

endmodule

bind symmetric_kernel_line_blur skl_checker u_skl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pix_i.valid),
  .in_ready_i     (pix_i.ready),
  .in_line_end_i  (pix_i.line_end_in),
  .out_valid_i    (pix_o.valid),
  .out_ready_i    (pix_o.ready),
  .out_red_i      (pix_o.red_out),
  .out_line_end_i (pix_o.line_end_out)
);

`default_nettype wire

[test/tb_symmetric_kernel_line_blur.sv]
`timescale 1ns / 100ps

module tb_symmetric_kernel_line_blur;
  import skl_pkg::*;

  localparam int RAND_ITEMS     = 440;
  localparam int CALM_ITEMS     = 60;
  localparam int HOLD_PHASE     = 2;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE         = 2 * (MAX_TAPS + 6);
  localparam int TAIL           = 4 * (MAX_TAPS + 6);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CHANNEL_BITS-1:0] SAT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] IDX_PAST_LIST = CFG_IDX_W'(CFG_COEF_D) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP       = '1;

  typedef enum logic {ROW_PIX, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    pix_t                  pix;
    logic                  le;
    logic                  typed;
    pix_t                  want;
  } stim_row_t;

  typedef struct packed {
    pix_t pix;
    logic le;
  } blur_res_t;

  // pixels written as {alpha, blue, green, red}
  localparam int DIR_ROWS = 31;
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    // reset setting, centre tap only
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'hFFFE_FFFE_FFFE_FFFE},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h0000_FFFF_8000_0001, 1'b1, 1'b1, 64'h0000_FFFE_8000_0001},
    // tap count of zero
    '{ROW_REG, CFG_TAP_COUNT, 64'd0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h1234_ABCD_0F0F_F0F0, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_0000_5555_AAAA, 1'b1, 1'b0, 64'h0},
    // full coefficients, tap count above range, short line saturates
    '{ROW_REG, CFG_COEF_A, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_COEF_B, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_COEF_C, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_COEF_D, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_TAP_COUNT, 64'd31, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
    '{ROW_REG, CFG_TAP_COUNT, 64'd17, 64'h0, 1'b0, 1'b0, 64'h0},
    // binomial-like kernel, tap count changed part way through a line
    '{ROW_REG, CFG_COEF_A, 64'h0000_1000_4000_6000, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_TAP_COUNT, 64'd3, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h0001_FFFF_7FFF_8000, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hFFFF_0001_8001_7FFE, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h0F0F_F0F0_3C3C_C3C3, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h5555_AAAA_0000_FFFF, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hAAAA_5555_FFFF_0000, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, CFG_TAP_COUNT, 64'd5, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h1111_2222_3333_4444, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'hEEEE_DDDD_CCCC_BBBB, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h8000_8000_8000_8000, 1'b0, 1'b0, 64'h0},
    '{ROW_PIX, CFG_TAP_COUNT, 64'h0, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 1'b0, 64'h0},
    // indexes past the register list
    '{ROW_REG, IDX_PAST_LIST, 64'hDEAD_BEEF_0BAD_F00D, 64'h0, 1'b0, 1'b0, 64'h0},
    '{ROW_REG, IDX_TOP, 64'h0123_4567_89AB_CDEF, 64'h0, 1'b0, 1'b0, 64'h0}
  };

  logic clk;
  logic rst_n;

  skl_in_if  pix_if ();
  skl_out_if res_if ();
  skl_cfg_if cfg_if ();

  symmetric_kernel_line_blur u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .pix_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // line blur predictor state
  logic [TAPCNT_W-1:0]   taps_reg;
  logic [CFG_DATA_W-1:0] coef_reg [NUM_COEF_WORDS];
  pix_t                  win_mem [WIN_DEPTH];
  int                    rcv_cnt;
  blur_res_t             blurred_q [$];

  int   fail_cnt;
  bit   calm;
  bit   long_hold_req;
  int   send_run;
  string chan_name [NUM_CHAN] = '{"red_out", "green_out", "blue_out", "alpha_out"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int taps_eff();
    int t;
    t = int'(taps_reg);
    if (t < 1) t = 1;
    if (t > MAX_TAPS) t = MAX_TAPS;
    return t;
  endfunction

  function automatic logic [63:0] coef_of(input int k);
    return 64'(coef_reg[k / COEFS_PER_WORD][(k % COEFS_PER_WORD) * COEF_W +: COEF_W]);
  endfunction

  // output for the position d behind the newest pixel, line start n behind it
  function automatic blur_res_t blur_one(input int d, input int n, input int taps,
                                         input logic last);
    blur_res_t   r;
    logic [63:0] acc;
    int          c;
    int          k;
    int          ri;
    int          li;
    for (c = 0; c < NUM_CHAN; c++) begin
      acc = coef_of(0) * 64'(win_mem[d][c]);
      for (k = 1; k < taps; k++) begin
        ri = (k >= d) ? 0 : d - k;
        li = (d + k < n) ? d + k : n;
        acc += coef_of(k) * (64'(win_mem[ri][c]) + 64'(win_mem[li][c]));
      end
      acc = (acc + 64'h8000) >> FRAC_BITS;
      if (acc > 64'(SAT_MAX)) acc = 64'(SAT_MAX);
      r.pix[c] = acc[CHANNEL_BITS-1:0];
    end
    r.le = last;
    return r;
  endfunction

  task automatic blur_accept(input pix_t p, input logic le, input logic typed,
                             input pix_t want);
    blur_res_t got [$];
    blur_res_t r;
    int        taps;
    int        n;
    int        d;
    int        i;
    taps = taps_eff();
    for (i = WIN_DEPTH - 1; i > 0; i--) win_mem[i] = win_mem[i-1];
    win_mem[0] = p;
    n = (rcv_cnt < WIN_DEPTH - 1) ? rcv_cnt : WIN_DEPTH - 1;
    if (!le) begin
      if (n >= taps - 1) got.push_back(blur_one(taps - 1, n, taps, 1'b0));
      if (rcv_cnt < WIN_DEPTH) rcv_cnt++;
    end else begin
      // flush of every pending position, line end on the last
      for (d = (n < taps - 1) ? n : taps - 1; d >= 0; d--) begin
        got.push_back(blur_one(d, n, taps, d == 0));
      end
      rcv_cnt = 0;
    end
    foreach (got[j]) begin
      r = got[j];
      if (typed) r.pix = want;
      blurred_q.push_back(r);
    end
  endtask

  task automatic send_pixel(input pix_t p, input logic le, input logic typed,
                            input pix_t want);
    if (!calm) begin
      if (send_run > 0) begin
        send_run--;
      end else begin
        pix_if.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        send_run = $urandom_range(0, 20);
      end
    end
    pix_if.valid       <= 1'b1;
    pix_if.red_in      <= p[0];
    pix_if.green_in    <= p[1];
    pix_if.blue_in     <= p[2];
    pix_if.alpha_in    <= p[3];
    pix_if.line_end_in <= le;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    blur_accept(p, le, typed, want);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    pix_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk);
    // pixels that give no result may still be in flight
    repeat (SETTLE) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_TAP_COUNT: taps_reg = val[TAPCNT_W-1:0];
      CFG_COEF_A:    coef_reg[0] = val;
      CFG_COEF_B:    coef_reg[1] = val;
      CFG_COEF_C:    coef_reg[2] = val;
      CFG_COEF_D:    coef_reg[3] = val;
      default:       ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // result receiver with random back-pressure
  initial begin
    int hold_left;
    int run_left;
    hold_left = 0;
    run_left  = 0;
    res_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else if (!calm) begin
          hold_left = $urandom_range(1, 15);
          run_left  = $urandom_range(0, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    blur_res_t exp_r;
    pix_t      act;
    if (rst_n && res_if.valid && res_if.ready) begin
      act = {res_if.alpha_out, res_if.blue_out, res_if.green_out, res_if.red_out};
      if (blurred_q.size() == 0) begin
        $error("result with no request pending: pixel %h line_end_out %b", act,
               res_if.line_end_out);
        fail_cnt++;
      end else begin
        exp_r = blurred_q.pop_front();
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (act[c] !== exp_r.pix[c]) begin
            $error("%s expected %0d actual %0d", chan_name[c], exp_r.pix[c], act[c]);
            fail_cnt++;
          end
        end
        if (res_if.line_end_out !== exp_r.le) begin
          $error("line_end_out expected %0d actual %0d", exp_r.le, res_if.line_end_out);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int stuck;
    stuck = 0;
    wait (rst_n);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t             row;
    pix_t                  pix;
    logic [CFG_DATA_W-1:0] word;
    int                    i;
    int                    j;
    int                    w;
    int                    mode;
    int                    sent;
    int                    phase;
    int                    phase_end;
    int                    t;
    int                    sel;
    int                    len;
    int                    tap_val;

    rst_n = 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.red_in      <= '0;
    pix_if.green_in    <= '0;
    pix_if.blue_in     <= '0;
    pix_if.alpha_in    <= '0;
    pix_if.line_end_in <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    fail_cnt      = 0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    send_run      = 0;
    taps_reg      = TAPCNT_W'(1);
    coef_reg      = '{64'd65535, 64'd0, 64'd0, 64'd0};
    rcv_cnt       = 0;
    for (i = 0; i < WIN_DEPTH; i++) win_mem[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.val);
      end else begin
        send_pixel(row.pix, row.le, row.typed, row.want);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      calm = (sent >= RAND_ITEMS - CALM_ITEMS);
      if (phase == 0) begin
        tap_val = MAX_TAPS;
      end else if (phase == 1) begin
        tap_val = 1;
      end else if ($urandom_range(0, 7) == 0) begin
        tap_val = $urandom_range(0, 31);
      end else begin
        tap_val = $urandom_range(1, MAX_TAPS);
      end
      write_reg(CFG_TAP_COUNT, CFG_DATA_W'(tap_val));
      for (w = 0; w < NUM_COEF_WORDS; w++) begin
        mode = $urandom_range(0, 7);
        for (j = 0; j < COEFS_PER_WORD; j++) begin
          if (mode < 4) begin
            word[j*COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 16'h1000));
          end else if (mode < 6) begin
            word[j*COEF_W +: COEF_W] = COEF_W'($urandom);
          end else if (mode == 6) begin
            word[j*COEF_W +: COEF_W] = '0;
          end else begin
            word[j*COEF_W +: COEF_W] = '1;
          end
        end
        write_reg(CFG_IDX_W'(CFG_COEF_A) + CFG_IDX_W'(w), word);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(IDX_PAST_LIST, IDX_TOP)), {$urandom, $urandom});
      end
      if (phase == HOLD_PHASE) begin
        // long receiver hold-off so the block fills and stalls its input
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
      end
      phase_end = sent + $urandom_range(30, 60);
      while (sent < phase_end) begin
        t   = taps_eff();
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          len = $urandom_range(1, 2 * t + 2);
        end else if (sel < 9) begin
          len = $urandom_range(1, t);
        end else begin
          len = $urandom_range(32, 70);
        end
        for (j = 0; j < len; j++) begin
          for (i = 0; i < NUM_CHAN; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              pix[i] = $urandom_range(0, 1) ? '1 : '0;
            end else begin
              pix[i] = CHANNEL_BITS'($urandom);
            end
          end
          send_pixel(pix, j == len - 1, 1'b0, '0);
          sent++;
        end
      end
      phase++;
    end

    pix_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
